[rtl/core/isadma_pkg.sv]
// ----------------------------------------------------------------------------
// isadma_pkg
// shared types, port constants and lookup functions for the dma setup block
// ----------------------------------------------------------------------------
package isadma_pkg;

  localparam logic [7:0] MASK_PORT_LO  = 8'h0A;
  localparam logic [7:0] MODE_PORT_LO  = 8'h0B;
  localparam logic [7:0] CLEAR_PORT_LO = 8'h0C;
  localparam logic [7:0] MASK_PORT_HI  = 8'hD4;
  localparam logic [7:0] MODE_PORT_HI  = 8'hD6;
  localparam logic [7:0] CLEAR_PORT_HI = 8'hD8;
  localparam logic [7:0] MASK_SET_BIT  = 8'h04;
  localparam logic [7:0] CLEAR_VALUE   = 8'hFF;

  localparam int QUEUE_DEPTH = 2;

  // classified request as it travels from front to back
  typedef struct packed {
    logic [2:0]  chan;
    logic [7:0]  mode;
    logic [23:0] addr;   // scaled address, page and low bytes
    logic [15:0] cnt;    // scaled count minus one, low 16 bits
  } item_t;

  // one write per step, one-hot
  typedef enum logic [9:0] {
    STEP_MASK     = 10'b0000000001,
    STEP_MODE     = 10'b0000000010,
    STEP_CLEAR_A  = 10'b0000000100,
    STEP_ADDR_LO  = 10'b0000001000,
    STEP_ADDR_HI  = 10'b0000010000,
    STEP_PAGE     = 10'b0000100000,
    STEP_CLEAR_C  = 10'b0001000000,
    STEP_COUNT_LO = 10'b0010000000,
    STEP_COUNT_HI = 10'b0100000000,
    STEP_UNMASK   = 10'b1000000000
  } step_t;

  function automatic logic [7:0] page_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0: p = 8'h87;
      3'd1: p = 8'h83;
      3'd2: p = 8'h81;
      3'd3: p = 8'h82;
      3'd4: p = 8'h8F;
      3'd5: p = 8'h8B;
      3'd6: p = 8'h89;
      default: p = 8'h8A;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] addr_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0: p = 8'h00;
      3'd1: p = 8'h02;
      3'd2: p = 8'h04;
      3'd3: p = 8'h06;
      3'd4: p = 8'hC0;
      3'd5: p = 8'hC4;
      3'd6: p = 8'hC8;
      default: p = 8'hCC;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] count_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0: p = 8'h01;
      3'd1: p = 8'h03;
      3'd2: p = 8'h05;
      3'd3: p = 8'h07;
      3'd4: p = 8'hC2;
      3'd5: p = 8'hC6;
      3'd6: p = 8'hCA;
      default: p = 8'hCE;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/isadma_front.sv]
// ----------------------------------------------------------------------------
// isadma_front
// checks the channel, scales address and count, and pushes into the queue
// ----------------------------------------------------------------------------
module isadma_front import isadma_pkg::*; (
  input  logic        start,
  input  logic        full,
  input  logic [7:0]  channel,
  input  logic [7:0]  mode_byte,
  input  logic [31:0] byte_address,
  input  logic [31:0] byte_count,
  output logic        busy,
  output logic        push,
  output item_t       item
);

  logic        wide;
  logic [15:0] cnt_scaled;

  assign busy = full;
  assign wide = channel[2];

  // channels above seven take a beat but produce nothing
  assign push = start && !full && (channel[7:3] == 5'd0);

  assign cnt_scaled = wide ? byte_count[16:1] : byte_count[15:0];

  assign item.chan = channel[2:0];
  assign item.mode = mode_byte;
  assign item.addr = wide ? byte_address[24:1] : byte_address[23:0];
  assign item.cnt  = cnt_scaled - 16'd1;

endmodule

[rtl/core/isadma_queue.sv]
// ----------------------------------------------------------------------------
// isadma_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module isadma_queue import isadma_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty,
  output logic  full
);

  item_t      mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign empty   = (fill == 2'd0);
  assign full    = (fill == 2'(QUEUE_DEPTH));
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/core/isadma_back.sv]
// ----------------------------------------------------------------------------
// isadma_back
// steps through the ten port writes of one request, one beat per cycle
// ----------------------------------------------------------------------------
module isadma_back import isadma_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      rd_item,
  input  logic       empty,
  output logic       pop,
  output logic       strobe,
  output logic [7:0] port,
  output logic [7:0] value,
  output logic       last
);

  item_t      cur;
  step_t      step;
  logic       active;
  logic       wide;
  logic [7:0] idx;
  logic [7:0] port_next;
  logic [7:0] value_next;

  assign wide = cur.chan[2];
  assign idx  = {6'd0, cur.chan[1:0]};
  assign pop  = (!active || step == STEP_UNMASK) && !empty;

  always_comb begin
    port_next  = 8'h00;
    value_next = 8'h00;
    unique case (step) inside
      STEP_MASK: begin
        port_next  = wide ? MASK_PORT_HI : MASK_PORT_LO;
        value_next = MASK_SET_BIT | idx;
      end
      STEP_MODE: begin
        port_next  = wide ? MODE_PORT_HI : MODE_PORT_LO;
        value_next = cur.mode | idx;
      end
      STEP_CLEAR_A, STEP_CLEAR_C: begin
        port_next  = wide ? CLEAR_PORT_HI : CLEAR_PORT_LO;
        value_next = CLEAR_VALUE;
      end
      STEP_ADDR_LO: begin
        port_next  = addr_port(cur.chan);
        value_next = cur.addr[7:0];
      end
      STEP_ADDR_HI: begin
        port_next  = addr_port(cur.chan);
        value_next = cur.addr[15:8];
      end
      STEP_PAGE: begin
        port_next  = page_port(cur.chan);
        value_next = cur.addr[23:16];
      end
      STEP_COUNT_LO: begin
        port_next  = count_port(cur.chan);
        value_next = cur.cnt[7:0];
      end
      STEP_COUNT_HI: begin
        port_next  = count_port(cur.chan);
        value_next = cur.cnt[15:8];
      end
      STEP_UNMASK: begin
        port_next  = wide ? MASK_PORT_HI : MASK_PORT_LO;
        value_next = idx;
      end
      default: begin
        port_next  = 8'h00;
        value_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_item;
    end
    if (active) begin
      port  <= port_next;
      value <= value_next;
      last  <= (step == STEP_UNMASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= STEP_MASK;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (!active || step == STEP_UNMASK) begin
        // next request follows the unmask beat with no gap
        active <= !empty;
        step   <= STEP_MASK;
      end else begin
        step <= step_t'({step[8:0], 1'b0});
      end
    end
  end

endmodule

[rtl/core/isa_dma_channel_program_sequencer_top.sv]
// ----------------------------------------------------------------------------
// isa_dma_channel_program_sequencer_top
// turns a channel setup request into the ten port writes for an 8237 pair
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         start & !busy        channel, mode_byte, byte_address,
//                                            byte_count
//  write     out        strobe (one cycle)   port, value, last
//
//  each valid request gives ten writes on consecutive cycles; the first
//  write leaves the back sequencer's output registers after the request has
//  passed the queue. throughput is set by the single write port it steps.
//  a two-entry queue lets requests be taken while writes are going out; busy
//  rises when it is full. channels above seven are taken and dropped.
//  rst is synchronous and empties the queue; writes cannot be stalled.
// ----------------------------------------------------------------------------
module isa_dma_channel_program_sequencer_top import isadma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  channel,
  input  logic [7:0]  mode_byte,
  input  logic [31:0] byte_address,
  input  logic [31:0] byte_count,
  output logic        strobe,
  output logic [7:0]  port,
  output logic [7:0]  value,
  output logic        last
);

  item_t wr_item;
  item_t rd_item;
  logic  push;
  logic  pop;
  logic  empty;
  logic  full;

  isadma_front u_front (
    .start        (start),
    .full         (full),
    .channel      (channel),
    .mode_byte    (mode_byte),
    .byte_address (byte_address),
    .byte_count   (byte_count),
    .busy         (busy),
    .push         (push),
    .item         (wr_item)
  );

  isadma_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (empty),
    .full    (full)
  );

  isadma_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rd_item (rd_item),
    .empty   (empty),
    .pop     (pop),
    .strobe  (strobe),
    .port    (port),
    .value   (value),
    .last    (last)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the isa dma channel setup sequencer against an in-bench predictor:
// a directed table of edge requests, then random requests under three
// sender idle patterns; every write beat is compared field by field in order
// ----------------------------------------------------------------------------
module testbench;
  import isadma_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int WRITES_PER_SETUP = 10;
  localparam int MAX_PRINTED = 100;

  // per-channel port maps, channel 0 in the low byte
  localparam logic [63:0] PAGE_PORTS  = {8'h8A, 8'h89, 8'h8B, 8'h8F,
                                         8'h82, 8'h81, 8'h83, 8'h87};
  localparam logic [63:0] ADDR_PORTS  = {8'hCC, 8'hC8, 8'hC4, 8'hC0,
                                         8'h06, 8'h04, 8'h02, 8'h00};
  localparam logic [63:0] COUNT_PORTS = {8'hCE, 8'hCA, 8'hC6, 8'hC2,
                                         8'h07, 8'h05, 8'h03, 8'h01};

  typedef struct packed {
    logic [7:0] port;
    logic [7:0] value;
    logic       last;
  } port_write_t;

  // typed rows carry a page byte and count word read straight off the spec
  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  mode;
    logic [31:0] addr;
    logic [31:0] cnt;
    bit          typed;
    logic [7:0]  page;
    logic [15:0] count;
  } setup_req_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  channel;
  logic [7:0]  mode_byte;
  logic [31:0] byte_address;
  logic [31:0] byte_count;
  logic        strobe;
  logic [7:0]  port;
  logic [7:0]  value;
  logic        last;

  bit          row_typed;
  logic [7:0]  row_page;
  logic [15:0] row_count;

  port_write_t pending_writes [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  isa_dma_channel_program_sequencer_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .channel      (channel),
    .mode_byte    (mode_byte),
    .byte_address (byte_address),
    .byte_count   (byte_count),
    .strobe       (strobe),
    .port         (port),
    .value        (value),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // the ten writes that program one channel, queued in bus order
  function automatic void queue_setup_writes(input logic [7:0] ch, input logic [7:0] mode,
                                             input logic [31:0] addr, input logic [31:0] cnt,
                                             input bit typed, input logic [7:0] typed_page,
                                             input logic [15:0] typed_count);
    port_write_t w [WRITES_PER_SETUP];
    logic        wide;
    logic [7:0]  idx;
    logic [7:0]  mask_p, mode_p, clr_p, ap, cp, pp;
    logic [31:0] a, c;
    if (ch > 8'd7) return;
    wide = ch[2];
    a = wide ? (addr >> 1) : addr;
    c = (wide ? (cnt >> 1) : cnt) - 32'd1;
    if (typed) begin
      a[23:16] = typed_page;
      c[15:0] = typed_count;
    end
    idx = {6'd0, ch[1:0]};
    mask_p = wide ? MASK_PORT_HI : MASK_PORT_LO;
    mode_p = wide ? MODE_PORT_HI : MODE_PORT_LO;
    clr_p = wide ? CLEAR_PORT_HI : CLEAR_PORT_LO;
    ap = ADDR_PORTS[ch[2:0]*8 +: 8];
    cp = COUNT_PORTS[ch[2:0]*8 +: 8];
    pp = PAGE_PORTS[ch[2:0]*8 +: 8];
    w[0] = '{mask_p, MASK_SET_BIT | idx, 1'b0};
    w[1] = '{mode_p, mode | idx, 1'b0};
    w[2] = '{clr_p, CLEAR_VALUE, 1'b0};
    w[3] = '{ap, a[7:0], 1'b0};
    w[4] = '{ap, a[15:8], 1'b0};
    w[5] = '{pp, a[23:16], 1'b0};
    w[6] = '{clr_p, CLEAR_VALUE, 1'b0};
    w[7] = '{cp, c[7:0], 1'b0};
    w[8] = '{cp, c[15:8], 1'b0};
    w[9] = '{mask_p, idx, 1'b1};
    foreach (w[k]) pending_writes.push_back(w[k]);
  endfunction

  always @(posedge clk) begin
    port_write_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        queue_setup_writes(channel, mode_byte, byte_address, byte_count,
                           row_typed, row_page, row_count);
      end
      if (strobe) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write port=%02h value=%02h last=%0b",
                                    port, value, last));
        end else begin
          want = pending_writes.pop_front();
          if (port !== want.port)
            report_mismatch($sformatf("port %02h, want %02h", port, want.port));
          if (value !== want.value)
            report_mismatch($sformatf("value %02h on port %02h, want %02h",
                                      value, want.port, want.value));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b on port %02h, want %0b",
                                      last, want.port, want.last));
        end
      end
      quiet_cycles <= ((start && !busy) || strobe) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // drive one request beat, idling first at the given rate
  task automatic send_request(input setup_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    channel      <= r.ch;
    mode_byte    <= r.mode;
    byte_address <= r.addr;
    byte_count   <= r.cnt;
    row_typed    <= r.typed;
    row_page     <= r.page;
    row_count    <= r.count;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic setup_req_t random_request();
    setup_req_t r;
    int         pick;
    r = '0;
    r.ch = ($urandom_range(99) < 12) ? 8'($urandom_range(255, 8)) : 8'($urandom_range(7));
    r.mode = 8'($urandom);
    pick = $urandom_range(9);
    r.addr = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd0 : 32'($urandom);
    pick = $urandom_range(9);
    r.cnt = (pick < 2) ? 32'($urandom_range(3)) : (pick == 2) ? 32'hFFFF_FFFF : 32'($urandom);
    return r;
  endfunction

  setup_req_t directed_reqs [$];
  int         idle_by_phase [3] = '{22, 86, 0};

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    channel      <= '0;
    mode_byte    <= '0;
    byte_address <= '0;
    byte_count   <= '0;
    row_typed    <= 1'b0;
    row_page     <= '0;
    row_count    <= '0;
    directed_reqs = '{
      // zero count wraps to all ones, on both controllers
      '{8'd0, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00, 16'hFFFF},
      '{8'd4, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00, 16'hFFFF},
      // count of one halves to zero on the 16-bit side
      '{8'd5, 8'h3C, 32'h0000_0000, 32'h0000_0001, 1'b1, 8'h00, 16'hFFFF},
      '{8'd1, 8'h55, 32'h0000_0000, 32'h0000_0001, 1'b1, 8'h00, 16'h0000},
      '{8'd6, 8'hAA, 32'h0000_0000, 32'h0000_0002, 1'b1, 8'h00, 16'h0000},
      // all ones everywhere
      '{8'd3, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFE},
      '{8'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFE},
      // address bits above the page are dropped
      '{8'd2, 8'h48, 32'hAB12_3456, 32'h0000_1000, 1'b1, 8'h12, 16'h0FFF},
      '{8'd6, 8'h48, 32'h01FF_FFFE, 32'h0000_1000, 1'b1, 8'hFF, 16'h07FF},
      '{8'd4, 8'h44, 32'hFE00_0000, 32'h0002_0000, 1'b1, 8'h00, 16'hFFFF},
      // channels above seven give no writes
      '{8'd8, 8'h12, 32'h1234_5678, 32'h0000_0100, 1'b0, 8'h00, 16'h0000},
      '{8'd255, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 16'h0000},
      '{8'h80, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00, 16'h0000},
      // every channel once, checked by the predictor
      '{8'd0, 8'h48, 32'h0012_3456, 32'h0000_4000, 1'b0, 8'h00, 16'h0000},
      '{8'd1, 8'h49, 32'h0034_5678, 32'h0000_0200, 1'b0, 8'h00, 16'h0000},
      '{8'd2, 8'h4A, 32'h0056_789A, 32'h0000_8000, 1'b0, 8'h00, 16'h0000},
      '{8'd3, 8'h4B, 32'h0078_9ABC, 32'h0001_0000, 1'b0, 8'h00, 16'h0000},
      '{8'd4, 8'h58, 32'h009A_BCDE, 32'h0000_4000, 1'b0, 8'h00, 16'h0000},
      '{8'd5, 8'h59, 32'h00BC_DEF0, 32'h0001_0001, 1'b0, 8'h00, 16'h0000},
      '{8'd6, 8'h5A, 32'h00DE_F012, 32'h0000_0003, 1'b0, 8'h00, 16'h0000},
      '{8'd7, 8'h5B, 32'h80F0_1235, 32'h8000_0000, 1'b0, 8'h00, 16'h0000}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_reqs[i]) send_request(directed_reqs[i], 0);
    foreach (idle_by_phase[p]) begin
      repeat (117) send_request(random_request(), idle_by_phase[p]);
    end
    start     <= 1'b0;
    row_typed <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
